@@ hw/rtl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the cache tag store
// Opcodes, sequencer states, register map and the item field widths.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int OP_W       = 2;
  localparam int WSEL_W     = 2;
  localparam int WOUT_W     = 2;
  localparam int OFS_W      = 5;
  localparam int IDX_W      = 3;
  localparam int SHAMT_W    = 6;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int IN_DATA_W  = 40;
  localparam int IN_PAD_W   = IN_DATA_W - ADDR_W - WSEL_W - 1;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - TAG_W - WOUT_W - 2;

  localparam logic [OFS_W-1:0] OFS_RST = 5'd8;
  localparam logic [IDX_W-1:0] IDX_RST = 3'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_VICTIM = 2'd1,
    OP_FILL   = 2'd2,
    OP_TOUCH  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic {
    REG_OFFSET = 1'b0,
    REG_INDEX  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

@@ hw/rtl/sacl_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// sacl_cmp_unit: shared compare and increment unit
// Compares tags or ages, one way per step, and forms the aged value.
// ----------------------------------------------------------------------------
module sacl_cmp_unit import sacl_pkg::*; (
  input  logic [TAG_W-1:0] a_i,
  input  logic [TAG_W-1:0] b_i,
  output cmp_res_t         res_o,
  output logic [TAG_W-1:0] inc_o
);

  assign res_o.eq = (a_i == b_i);
  assign res_o.gt = (a_i > b_i);
  assign inc_o    = a_i + TAG_W'(1);

endmodule

@@ hw/rtl/set_assoc_cache_tag_lru_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_top: set-associative tag store with age-counter LRU
// Lookup, victim select, line fill and LRU touch over one set per item.
// ----------------------------------------------------------------------------
// One item at a time: an accepted item passes through address decode, one
// synchronous read of the set's line state, WAYS steps of the single compare
// unit that visits one way per cycle, write-back of the set's state and
// result load. After reset a clearing pass writes the line state of every
// set, with in_tready low; configuration writes are taken throughout.
// Result fields not used by an opcode read as zero.
module set_assoc_cache_tag_lru_top import sacl_pkg::*; #(
  parameter int WAYS     = 4,
  parameter int SET_BITS = 6,
  parameter int AGE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: address[31:0], way_select[33:32], fill_dirty[34], zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: opcode[1:0]
  input  logic [OP_W-1:0]       in_tuser,
  // out_tdata: hit[0], way_out[2:1], writeback_needed[3], victim_tag[35:4], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  localparam int NUM_SETS    = 1 << SET_BITS;
  localparam int SET_W       = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int META_DEPTH  = 1 << SET_W;
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_AW      = SET_W + WAY_W;
  localparam int TAG_DEPTH   = 1 << TAG_AW;
  localparam int META_W      = 2 * WAYS + WAYS * AGE_BITS;
  localparam int AGE_MAX_INT = (1 << AGE_BITS) - 1;
  localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;
  localparam logic [SET_W-1:0]    SET_MASK = SET_W'(NUM_SETS - 1);
  localparam logic [WAY_W-1:0]    WAY_LAST = WAY_W'(WAYS - 1);

  state_t state_r, state_nxt;

  logic [OFS_W-1:0]  ofs_r;
  logic [IDX_W-1:0]  idx_r;
  logic              cfg_we;

  op_t               op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [WSEL_W-1:0] wsel_r;
  logic              fdirty_r;

  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic [SET_W-1:0]  clr_cnt_r;
  logic [WAY_W-1:0]  way_cnt_r;

  logic                hit_r;
  logic [WAY_W-1:0]    way_r;
  logic [AGE_BITS-1:0] best_age_r;
  logic [TAG_W-1:0]    best_tag_r;
  logic                best_wb_r;
  logic [AGE_BITS-1:0] ages_r [WAYS];

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic                  in_acc;
  logic                  load_out;
  logic                  tag_we;
  logic                  meta_we;
  logic                  clearing;

  // decode
  logic [IDX_W-1:0]   ib_used;
  logic [SHAMT_W-1:0] tag_shamt;
  logic [ADDR_W-1:0]  set_shift;
  logic [ADDR_W-1:0]  idx_mask;
  logic [SET_W-1:0]   set_calc;
  logic [TAG_W-1:0]   tag_calc;

  // memories
  logic [TAG_W-1:0]  tag_mem [TAG_DEPTH];
  logic [TAG_W-1:0]  tag_q;
  logic [TAG_AW-1:0] tag_ra;
  logic [TAG_AW-1:0] tag_wa;
  logic [META_W-1:0] meta_mem [META_DEPTH];
  logic [META_W-1:0] meta_q;
  logic [SET_W-1:0]  meta_wa;
  logic [META_W-1:0] meta_wdata;

  logic [WAYS-1:0]          valid_q;
  logic [WAYS-1:0]          dirty_q;
  logic [AGE_BITS-1:0]      age_q [WAYS];
  logic [WAYS*AGE_BITS-1:0] ages_vec;
  logic [WAYS*AGE_BITS-1:0] age_rst_vec;

  // scan step
  logic [WAY_W-1:0]    wsel_way;
  logic                wsel_ok;
  logic [WAYS-1:0]     wsel_hot;
  logic [AGE_BITS-1:0] age_k;
  logic                valid_k;
  logic                dirty_k;
  logic                is_sel;
  logic [TAG_W-1:0]    cmp_a;
  logic [TAG_W-1:0]    cmp_b;
  logic [TAG_W-1:0]    cmp_inc;
  cmp_res_t            cmp_res;

  logic                  res_wb;
  logic [OUT_DATA_W-1:0] out_tdata_nxt;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r <= OFS_RST;
      idx_r <= IDX_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_paddr[2]))
        REG_OFFSET: ofs_r <= cfg_pwdata[OFS_W-1:0];
        REG_INDEX:  idx_r <= cfg_pwdata[IDX_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[2]))
      REG_OFFSET: cfg_prdata = CFG_DW'(ofs_r);
      REG_INDEX:  cfg_prdata = CFG_DW'(idx_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clearing  = 1'b0;
    tag_we    = 1'b0;
    meta_we   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clearing = 1'b1;
        meta_we  = 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (way_cnt_r == WAY_LAST) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        meta_we   = wsel_ok && (op_r == OP_FILL || op_r == OP_TOUCH);
        tag_we    = wsel_ok && (op_r == OP_FILL);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  // hold the item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= op_t'(in_tuser);
      addr_r   <= in_tdata[ADDR_W-1:0];
      wsel_r   <= in_tdata[ADDR_W +: WSEL_W];
      fdirty_r <= in_tdata[ADDR_W + WSEL_W];
    end
  end

  // --------------------------------------------------------------------------
  // address decode
  // --------------------------------------------------------------------------
  assign ib_used   = (int'(idx_r) > SET_BITS) ? IDX_W'(SET_BITS) : idx_r;
  assign tag_shamt = SHAMT_W'(ofs_r) + SHAMT_W'(ib_used);
  assign tag_calc  = TAG_W'(addr_r >> tag_shamt);
  assign set_shift = addr_r >> ofs_r;
  assign idx_mask  = (ADDR_W'(1) << ib_used) - ADDR_W'(1);
  assign set_calc  = SET_W'(set_shift & idx_mask) & SET_MASK;

  always_ff @(posedge clk) begin
    if (state_r == ST_DECODE) begin
      set_r <= set_calc;
      tag_r <= tag_calc;
    end
  end

  // --------------------------------------------------------------------------
  // tag and line state memories
  // --------------------------------------------------------------------------
  assign wsel_way = WAY_W'(wsel_r);
  assign wsel_ok  = (int'(wsel_r) < WAYS);
  assign wsel_hot = WAYS'(1) << wsel_way;

  assign tag_ra = {set_r, (state_r == ST_READ) ? WAY_W'(0) : way_cnt_r + WAY_W'(1)};
  assign tag_wa = {set_r, wsel_way};

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_r;
    end
    tag_q <= tag_mem[tag_ra];
  end

  assign valid_q = meta_q[WAYS-1:0];
  assign dirty_q = meta_q[2*WAYS-1:WAYS];

  for (genvar k = 0; k < WAYS; k++) begin : g_way
    assign age_q[k] = meta_q[2*WAYS + k*AGE_BITS +: AGE_BITS];
    assign ages_vec[k*AGE_BITS +: AGE_BITS] = ages_r[k];
    assign age_rst_vec[k*AGE_BITS +: AGE_BITS] =
      (k > AGE_MAX_INT) ? AGE_MAX : AGE_BITS'(k);
  end

  always_comb begin
    meta_wa    = set_r;
    meta_wdata = meta_q;
    if (clearing) begin
      meta_wa    = clr_cnt_r;
      meta_wdata = {age_rst_vec, {WAYS{1'b0}}, {WAYS{1'b0}}};
    end else if (op_r == OP_FILL) begin
      meta_wdata = {meta_q[META_W-1:2*WAYS],
                    (dirty_q & ~wsel_hot) | (fdirty_r ? wsel_hot : '0),
                    valid_q | wsel_hot};
    end else begin
      meta_wdata = {ages_vec, dirty_q, valid_q};
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wdata;
    end
    meta_q <= meta_mem[set_r];
  end

  // --------------------------------------------------------------------------
  // way scan through the shared unit
  // --------------------------------------------------------------------------
  assign age_k   = age_q[way_cnt_r];
  assign valid_k = valid_q[way_cnt_r];
  assign dirty_k = dirty_q[way_cnt_r];
  assign is_sel  = wsel_ok && (way_cnt_r == wsel_way);

  always_comb begin
    case (op_r)
      OP_LOOKUP: begin
        cmp_a = tag_q;
        cmp_b = tag_r;
      end
      OP_VICTIM: begin
        cmp_a = TAG_W'(age_k);
        cmp_b = TAG_W'(best_age_r);
      end
      default: begin
        cmp_a = TAG_W'(age_k);
        cmp_b = TAG_W'(AGE_MAX);
      end
    endcase
  end

  sacl_cmp_unit u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res),
    .inc_o (cmp_inc)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      way_cnt_r <= '0;
      hit_r     <= 1'b0;
      way_r     <= '0;
      best_wb_r <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      way_cnt_r <= way_cnt_r + WAY_W'(1);
      case (op_r)
        OP_LOOKUP: begin
          if (!hit_r && valid_k && cmp_res.eq) begin
            hit_r <= 1'b1;
            way_r <= way_cnt_r;
          end
        end
        OP_VICTIM: begin
          if (way_cnt_r == '0 || cmp_res.gt) begin
            way_r      <= way_cnt_r;
            best_age_r <= age_k;
            best_tag_r <= tag_q;
            best_wb_r  <= valid_k && dirty_k;
          end
        end
        OP_TOUCH: begin
          if (is_sel) begin
            ages_r[way_cnt_r] <= '0;
          end else if (!cmp_res.eq && !cmp_res.gt) begin
            ages_r[way_cnt_r] <= AGE_BITS'(cmp_inc);
          end else begin
            ages_r[way_cnt_r] <= age_k;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  assign res_wb = (op_r == OP_VICTIM) && best_wb_r;
  assign out_tdata_nxt = {{OUT_PAD_W{1'b0}},
                          res_wb ? best_tag_r : TAG_W'(0),
                          res_wb,
                          WOUT_W'(way_r),
                          (op_r == OP_LOOKUP) && hit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ hw/rtl/sacl_checker.sv @@
// ----------------------------------------------------------------------------
// sacl_checker: port-level checks on the cache tag store
// Watches the item channels of the top level over time.
// ----------------------------------------------------------------------------
module sacl_checker import sacl_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // drop ready for the item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in flight");

  a_hit_wb_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[WOUT_W + 1]))
    else $error("hit and write-back flagged together");

  a_vtag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[WOUT_W + 1] |-> out_tdata[WOUT_W + 2 +: TAG_W] == '0)
    else $error("victim tag set without write-back");

endmodule

bind set_assoc_cache_tag_lru_top sacl_checker u_sacl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
